### rtl/bmm_pkg.sv
`default_nettype none

package bmm_pkg;

	// Field widths fixed by the interface
	localparam int IDX_W     = 10;
	localparam int VAL_W     = 16;
	localparam int DIM_W     = 5;
	localparam int LAY_W     = 3;
	localparam int PROD_W    = 2 * VAL_W;
	localparam int SUM_W     = 40;
	localparam int CFG_IDX_W = 2;

	// Index decomposition runs two quotient bits per cycle
	localparam int DIV_STEPS = IDX_W / 2;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_WRITE_A = 2'd0,
		OP_WRITE_B = 2'd1,
		OP_COMPUTE = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INNER  = 2'd0,
		CFG_ROWS   = 2'd1,
		CFG_COLS   = 2'd2,
		CFG_LAYERS = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		K_WRITE_A,
		K_WRITE_B,
		K_CALC
	} kind_t;

	// Effective shape after clamping
	typedef struct packed {
		logic [DIM_W-1:0] inner;
		logic [DIM_W-1:0] rows;
		logic [DIM_W-1:0] cols;
		logic [LAY_W-1:0] layers;
	} dims_t;

	// One classified transaction handed from front to back
	typedef struct packed {
		kind_t            kind;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] value;
		logic [IDX_W-1:0] a_base;
		logic [IDX_W-1:0] b_base;
	} queue_entry_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_DIV_COL,
		F_DIV_ROW,
		F_BASE_A,
		F_BASE_B,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_RUN,
		B_DRAIN
	} back_state_t;

endpackage

`default_nettype wire

### rtl/bmm_ram.sv
`default_nettype none

module bmm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one word, read one word with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/bmm_queue.sv
`default_nettype none

module bmm_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire bmm_pkg::queue_entry_t push_entry,
	output logic                       full,
	input  wire logic                  pop,
	output bmm_pkg::queue_entry_t      head,
	output logic                       empty
);

	bmm_pkg::queue_entry_t             entries_q [bmm_pkg::QUEUE_DEPTH];
	logic [bmm_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [bmm_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [bmm_pkg::QCNT_W-1:0]        count_q;

	localparam logic [bmm_pkg::QPTR_W-1:0] PTR_LAST = bmm_pkg::QPTR_W'(bmm_pkg::QUEUE_DEPTH - 1);
	localparam logic [bmm_pkg::QCNT_W-1:0] CNT_FULL = bmm_pkg::QCNT_W'(bmm_pkg::QUEUE_DEPTH);

	assign full  = (count_q == CNT_FULL);
	assign empty = (count_q == '0);
	assign head  = entries_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/bmm_front.sv
`default_nettype none

module bmm_front #(
	parameter int STORE_DEPTH = 1024
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire bmm_pkg::dims_t               dims,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [1:0]                   operation,
	input  wire logic [bmm_pkg::IDX_W-1:0]    flat_index,
	input  wire logic [bmm_pkg::VAL_W-1:0]    element_value,
	input  wire logic                         q_full,
	output logic                              push,
	output bmm_pkg::queue_entry_t             push_entry
);

	localparam logic [bmm_pkg::DIV_CNT_W-1:0] DIV_LAST = bmm_pkg::DIV_CNT_W'(bmm_pkg::DIV_STEPS - 1);

	bmm_pkg::front_state_t              state_q;
	bmm_pkg::front_state_t              state_d;

	logic [bmm_pkg::DIV_CNT_W-1:0]      cnt_q;
	logic [bmm_pkg::DIM_W-1:0]          rem_q;
	logic [bmm_pkg::IDX_W-1:0]          quo_q;
	logic [bmm_pkg::DIM_W-1:0]          div_q;
	logic [bmm_pkg::DIM_W-1:0]          col_q;
	logic [bmm_pkg::IDX_W-1:0]          q1_q;
	logic [bmm_pkg::IDX_W-1:0]          idx_q;
	logic [bmm_pkg::IDX_W-1:0]          a_base_q;
	logic [bmm_pkg::IDX_W-1:0]          lay_in_q;
	logic [bmm_pkg::IDX_W-1:0]          b_base_q;

	logic                               accept;
	logic                               is_write;
	logic                               in_store;
	logic                               div_last;
	logic [bmm_pkg::DIM_W:0]            r1;
	logic [bmm_pkg::DIM_W:0]            r2;
	logic [bmm_pkg::DIM_W-1:0]          r1_sub;
	logic [bmm_pkg::DIM_W-1:0]          rem_next;
	logic                               bit1;
	logic                               bit2;
	logic [bmm_pkg::IDX_W-1:0]          quo_next;

	assign accept   = start && !busy;
	assign is_write = (operation == bmm_pkg::OP_WRITE_A) || (operation == bmm_pkg::OP_WRITE_B);
	assign in_store = (32'(flat_index) < STORE_DEPTH);
	assign div_last = (cnt_q == DIV_LAST);

	// Two restoring division steps per cycle
	always_comb begin
		r1     = {rem_q, quo_q[bmm_pkg::IDX_W-1]};
		bit1   = (r1 >= {1'b0, div_q});
		r1_sub = bit1 ? bmm_pkg::DIM_W'(r1 - {1'b0, div_q}) : r1[bmm_pkg::DIM_W-1:0];
		r2     = {r1_sub, quo_q[bmm_pkg::IDX_W-2]};
		bit2   = (r2 >= {1'b0, div_q});
		rem_next = bit2 ? bmm_pkg::DIM_W'(r2 - {1'b0, div_q}) : r2[bmm_pkg::DIM_W-1:0];
		quo_next = {quo_q[bmm_pkg::IDX_W-3:0], bit1, bit2};
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bmm_pkg::F_IDLE: begin
				if (accept && (operation == bmm_pkg::OP_COMPUTE)) begin
					state_d = bmm_pkg::F_DIV_COL;
				end
			end
			bmm_pkg::F_DIV_COL: begin
				if (div_last) begin
					state_d = bmm_pkg::F_DIV_ROW;
				end
			end
			bmm_pkg::F_DIV_ROW: begin
				if (div_last) begin
					// drop a cell beyond the last layer
					if (quo_next < bmm_pkg::IDX_W'(dims.layers)) begin
						state_d = bmm_pkg::F_BASE_A;
					end else begin
						state_d = bmm_pkg::F_IDLE;
					end
				end
			end
			bmm_pkg::F_BASE_A: state_d = bmm_pkg::F_BASE_B;
			bmm_pkg::F_BASE_B: state_d = bmm_pkg::F_PUSH;
			bmm_pkg::F_PUSH: begin
				if (!q_full) begin
					state_d = bmm_pkg::F_IDLE;
				end
			end
			default: state_d = bmm_pkg::F_IDLE;
		endcase
	end

	// Outputs: in-range writes queue at once, computes after classification
	always_comb begin
		busy       = (state_q != bmm_pkg::F_IDLE) || q_full;
		push       = 1'b0;
		push_entry = '{kind: bmm_pkg::K_CALC, idx: idx_q, value: '0,
			a_base: a_base_q, b_base: b_base_q};
		case (state_q)
			bmm_pkg::F_IDLE: begin
				push = accept && is_write && in_store;
				push_entry.kind  = (operation == bmm_pkg::OP_WRITE_A) ?
					bmm_pkg::K_WRITE_A : bmm_pkg::K_WRITE_B;
				push_entry.idx   = flat_index;
				push_entry.value = element_value;
			end
			bmm_pkg::F_PUSH: begin
				push = !q_full;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmm_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Divider and address base datapath
	always_ff @(posedge clk) begin
		case (state_q)
			bmm_pkg::F_IDLE: begin
				if (accept) begin
					idx_q <= flat_index;
					rem_q <= '0;
					quo_q <= flat_index;
					div_q <= dims.cols;
					cnt_q <= '0;
				end
			end
			bmm_pkg::F_DIV_COL: begin
				if (div_last) begin
					// column is the remainder, restart on the row count
					col_q <= rem_next;
					q1_q  <= quo_next;
					quo_q <= quo_next;
					rem_q <= '0;
					div_q <= dims.rows;
					cnt_q <= '0;
				end else begin
					rem_q <= rem_next;
					quo_q <= quo_next;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			bmm_pkg::F_DIV_ROW: begin
				rem_q <= rem_next;
				quo_q <= quo_next;
				cnt_q <= cnt_q + 1'b1;
			end
			bmm_pkg::F_BASE_A: begin
				a_base_q <= bmm_pkg::IDX_W'(q1_q * dims.inner);
				lay_in_q <= bmm_pkg::IDX_W'(quo_q[bmm_pkg::LAY_W-1:0]) *
					bmm_pkg::IDX_W'(dims.inner);
			end
			bmm_pkg::F_BASE_B: begin
				b_base_q <= bmm_pkg::IDX_W'(lay_in_q * dims.cols + col_q);
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/bmm_back.sv
`default_nettype none

module bmm_back #(
	parameter int RAM_DEPTH = 1024
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire bmm_pkg::dims_t               dims,
	input  wire logic                         q_empty,
	input  wire bmm_pkg::queue_entry_t        head,
	output logic                              pop,
	output logic                              done,
	output logic signed [bmm_pkg::SUM_W-1:0]  cell_value,
	output logic [bmm_pkg::IDX_W-1:0]         cell_index
);

	localparam int AW = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

	bmm_pkg::back_state_t                     state_q;
	bmm_pkg::back_state_t                     state_d;

	logic [bmm_pkg::DIM_W-1:0]                k_q;
	logic [bmm_pkg::IDX_W-1:0]                a_addr_q;
	logic [bmm_pkg::IDX_W-1:0]                b_addr_q;
	logic [bmm_pkg::IDX_W-1:0]                cidx_q;
	logic signed [bmm_pkg::SUM_W-1:0]         acc_q;
	logic                                     done_q;
	logic signed [bmm_pkg::SUM_W-1:0]         value_q;
	logic [bmm_pkg::IDX_W-1:0]                index_q;

	logic                                     v_s1;
	logic                                     last_s1;
	logic                                     v_s2;
	logic                                     last_s2;
	logic signed [bmm_pkg::PROD_W-1:0]        prod_s2;

	logic                                     issue;
	logic                                     last_k;
	logic                                     we_a;
	logic                                     we_b;
	logic                                     start_calc;
	logic [bmm_pkg::VAL_W-1:0]                a_rdata;
	logic [bmm_pkg::VAL_W-1:0]                b_rdata;
	logic signed [bmm_pkg::SUM_W-1:0]         sum;

	assign last_k = (k_q == dims.inner - 1'b1);
	assign sum    = acc_q + bmm_pkg::SUM_W'(prod_s2);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bmm_pkg::B_IDLE: begin
				if (!q_empty && (head.kind == bmm_pkg::K_CALC)) begin
					state_d = bmm_pkg::B_RUN;
				end
			end
			bmm_pkg::B_RUN: begin
				if (last_k) begin
					state_d = bmm_pkg::B_DRAIN;
				end
			end
			bmm_pkg::B_DRAIN: begin
				if (v_s2 && last_s2) begin
					state_d = bmm_pkg::B_IDLE;
				end
			end
			default: state_d = bmm_pkg::B_IDLE;
		endcase
	end

	// Outputs: pop and store writes in idle, operand reads while running
	always_comb begin
		pop        = 1'b0;
		we_a       = 1'b0;
		we_b       = 1'b0;
		start_calc = 1'b0;
		issue      = 1'b0;
		case (state_q)
			bmm_pkg::B_IDLE: begin
				pop        = !q_empty;
				we_a       = !q_empty && (head.kind == bmm_pkg::K_WRITE_A);
				we_b       = !q_empty && (head.kind == bmm_pkg::K_WRITE_B);
				start_calc = !q_empty && (head.kind == bmm_pkg::K_CALC);
			end
			bmm_pkg::B_RUN: begin
				issue = 1'b1;
			end
			default: begin
				issue = 1'b0;
			end
		endcase
	end

	bmm_ram #(
		.WIDTH (bmm_pkg::VAL_W),
		.DEPTH (RAM_DEPTH)
	) u_a_ram (
		.clk   (clk),
		.we    (we_a),
		.waddr (head.idx[AW-1:0]),
		.wdata (head.value),
		.re    (issue),
		.raddr (a_addr_q[AW-1:0]),
		.rdata (a_rdata)
	);

	bmm_ram #(
		.WIDTH (bmm_pkg::VAL_W),
		.DEPTH (RAM_DEPTH)
	) u_b_ram (
		.clk   (clk),
		.we    (we_b),
		.waddr (head.idx[AW-1:0]),
		.wdata (head.value),
		.re    (issue),
		.raddr (b_addr_q[AW-1:0]),
		.rdata (b_rdata)
	);

	// Walk the inner dimension: A steps by one, B by a row
	always_ff @(posedge clk) begin
		if (start_calc) begin
			k_q      <= '0;
			a_addr_q <= head.a_base;
			b_addr_q <= head.b_base;
			cidx_q   <= head.idx;
		end else if (issue) begin
			k_q      <= k_q + 1'b1;
			a_addr_q <= a_addr_q + 1'b1;
			b_addr_q <= b_addr_q + bmm_pkg::IDX_W'(dims.cols);
		end
	end

	// Multiply stage
	always_ff @(posedge clk) begin
		prod_s2 <= $signed(a_rdata) * $signed(b_rdata);
	end

	// Control state and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmm_pkg::B_IDLE;
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
			done_q  <= 1'b0;
			acc_q   <= '0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			last_s1 <= issue && last_k;
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			done_q  <= v_s2 && last_s2;
			// accumulate, clear after the last term
			if (v_s2) begin
				acc_q <= last_s2 ? '0 : sum;
			end
		end
	end

	// Hold the finished cell for its strobe cycle
	always_ff @(posedge clk) begin
		if (v_s2 && last_s2) begin
			value_q <= sum;
			index_q <= cidx_q;
		end
	end

	assign done       = done_q;
	assign cell_value = value_q;
	assign cell_index = index_q;

endmodule

`default_nettype wire

### rtl/batched_matrix_multiply.sv
`default_nettype none

// Channel   | Handshake                  | Payload
// ----------+----------------------------+------------------------------------------
// command   | start in, busy out         | operation, flat_index, element_value
// result    | done out (one-cycle pulse) | cell_value, cell_index
// config    | cfg_valid in, cfg_ready out| cfg_index, cfg_data
//
// Element writes are taken one per cycle while the front is idle and the
// two-entry queue has room. A compute passes through the front as two radix-4
// divisions that split the flat index, then the A and B base steps; the back
// runs one multiply-accumulate per cycle on the single read port of each store.
// Stores need no clearing after reset; config is always ready.
// Results cannot be held off: done pulses for one cycle per computed cell.

module batched_matrix_multiply #(
	parameter int MAX_DIM    = 16,
	parameter int MAX_LAYERS = 4
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [1:0]                       operation,
	input  wire logic [bmm_pkg::IDX_W-1:0]        flat_index,
	input  wire logic signed [bmm_pkg::VAL_W-1:0] element_value,
	output logic                                  done,
	output logic signed [bmm_pkg::SUM_W-1:0]      cell_value,
	output logic [bmm_pkg::IDX_W-1:0]             cell_index,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [bmm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [bmm_pkg::DIM_W-1:0]        cfg_data
);

	localparam int STORE_DEPTH = MAX_DIM * MAX_DIM * MAX_LAYERS;
	localparam int IDX_SPAN    = 2 ** bmm_pkg::IDX_W;
	localparam int RAM_DEPTH   = (STORE_DEPTH < IDX_SPAN) ? STORE_DEPTH : IDX_SPAN;

	logic [bmm_pkg::DIM_W-1:0]    inner_q;
	logic [bmm_pkg::DIM_W-1:0]    rows_q;
	logic [bmm_pkg::DIM_W-1:0]    cols_q;
	logic [bmm_pkg::LAY_W-1:0]    layers_q;
	bmm_pkg::dims_t               dims;

	logic                         q_push;
	bmm_pkg::queue_entry_t        q_push_entry;
	logic                         q_full;
	logic                         q_pop;
	bmm_pkg::queue_entry_t        q_head;
	logic                         q_empty;

	assign cfg_ready = 1'b1;

	// Shape registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q  <= bmm_pkg::DIM_W'(16);
			rows_q   <= bmm_pkg::DIM_W'(16);
			cols_q   <= bmm_pkg::DIM_W'(16);
			layers_q <= bmm_pkg::LAY_W'(4);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bmm_pkg::CFG_INNER:  inner_q  <= cfg_data;
				bmm_pkg::CFG_ROWS:   rows_q   <= cfg_data;
				bmm_pkg::CFG_COLS:   cols_q   <= cfg_data;
				bmm_pkg::CFG_LAYERS: layers_q <= cfg_data[bmm_pkg::LAY_W-1:0];
				default: layers_q <= layers_q;
			endcase
		end
	end

	// Clamp each shape register into one to its maximum
	always_comb begin
		dims.inner = (inner_q == '0) ? bmm_pkg::DIM_W'(1) :
			(32'(inner_q) > MAX_DIM) ? bmm_pkg::DIM_W'(MAX_DIM) : inner_q;
		dims.rows = (rows_q == '0) ? bmm_pkg::DIM_W'(1) :
			(32'(rows_q) > MAX_DIM) ? bmm_pkg::DIM_W'(MAX_DIM) : rows_q;
		dims.cols = (cols_q == '0) ? bmm_pkg::DIM_W'(1) :
			(32'(cols_q) > MAX_DIM) ? bmm_pkg::DIM_W'(MAX_DIM) : cols_q;
		dims.layers = (layers_q == '0) ? bmm_pkg::LAY_W'(1) :
			(32'(layers_q) > MAX_LAYERS) ? bmm_pkg::LAY_W'(MAX_LAYERS) : layers_q;
	end

	bmm_front #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.dims          (dims),
		.start         (start),
		.busy          (busy),
		.operation     (operation),
		.flat_index    (flat_index),
		.element_value (element_value),
		.q_full        (q_full),
		.push          (q_push),
		.push_entry    (q_push_entry)
	);

	bmm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head       (q_head),
		.empty      (q_empty)
	);

	bmm_back #(
		.RAM_DEPTH (RAM_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.dims       (dims),
		.q_empty    (q_empty),
		.head       (q_head),
		.pop        (q_pop),
		.done       (done),
		.cell_value (cell_value),
		.cell_index (cell_index)
	);

endmodule

`default_nettype wire

### tb/tb_batched_matrix_multiply.sv
`timescale 1ns / 1ps

module tb_batched_matrix_multiply;

	localparam int MAX_DIM      = 16;
	localparam int MAX_LAYERS   = 4;
	localparam int STORE_DEPTH  = MAX_DIM * MAX_DIM * MAX_LAYERS;
	localparam int DRAIN_CYCLES = 100;
	localparam int STALL_LIMIT  = 2000;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 166;
	localparam int PICK         = 99;
	localparam int PLAN_ROWS    = 25;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic                                clk;
	logic                                arst_n;
	logic                                start;
	logic                                busy;
	logic [1:0]                          operation;
	logic [bmm_pkg::IDX_W-1:0]           flat_index;
	logic signed [bmm_pkg::VAL_W-1:0]    element_value;
	logic                                done;
	logic signed [bmm_pkg::SUM_W-1:0]    cell_value;
	logic [bmm_pkg::IDX_W-1:0]           cell_index;
	logic                                cfg_valid;
	logic                                cfg_ready;
	logic [bmm_pkg::CFG_IDX_W-1:0]       cfg_index;
	logic [bmm_pkg::DIM_W-1:0]           cfg_data;

	batched_matrix_multiply #(
		.MAX_DIM(MAX_DIM),
		.MAX_LAYERS(MAX_LAYERS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.flat_index(flat_index),
		.element_value(element_value),
		.done(done),
		.cell_value(cell_value),
		.cell_index(cell_index),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	typedef struct {
		logic signed [bmm_pkg::SUM_W-1:0] value;
		logic [bmm_pkg::IDX_W-1:0]        index;
	} cell_t;

	// One directed step: a command transaction or a register write
	typedef struct {
		bit                               is_cfg;
		logic [1:0]                       code;
		logic [bmm_pkg::IDX_W-1:0]        idx;
		logic [bmm_pkg::VAL_W-1:0]        data;
		bit                               typed;
		logic signed [bmm_pkg::SUM_W-1:0] want;
	} step_t;

	// Shadow copy of the matrix stores and shape registers
	logic signed [bmm_pkg::VAL_W-1:0] a_mem [STORE_DEPTH];
	logic signed [bmm_pkg::VAL_W-1:0] b_mem [STORE_DEPTH];
	bit                               a_set [STORE_DEPTH];
	bit                               b_set [STORE_DEPTH];
	logic [bmm_pkg::DIM_W-1:0]        inner_reg;
	logic [bmm_pkg::DIM_W-1:0]        rows_reg;
	logic [bmm_pkg::DIM_W-1:0]        cols_reg;
	logic [bmm_pkg::LAY_W-1:0]        layers_reg;

	cell_t       pending_cells [$];
	int          failures;
	int          cells_checked;
	int          items_sent;
	int          phase_items;
	int          gap_pct;
	int          stall_cycles;

	step_t plan [PLAN_ROWS] = '{
		'{1'b0, OP_UNUSED,           10'd1023, 16'hFFFF, 1'b0, '0},
		'{1'b0, bmm_pkg::OP_WRITE_A, 10'd1023, 16'h7FFF, 1'b0, '0},
		'{1'b0, bmm_pkg::OP_WRITE_B, 10'd1023, 16'h8000, 1'b0, '0},
		// zero shape registers act as one
		'{1'b1, bmm_pkg::CFG_INNER,  10'd0,    16'd0,    1'b0, '0},
		'{1'b1, bmm_pkg::CFG_ROWS,   10'd0,    16'd0,    1'b0, '0},
		'{1'b1, bmm_pkg::CFG_COLS,   10'd0,    16'd0,    1'b0, '0},
		'{1'b1, bmm_pkg::CFG_LAYERS, 10'd0,    16'd0,    1'b0, '0},
		'{1'b0, bmm_pkg::OP_WRITE_A, 10'd0,    16'h8000, 1'b0, '0},
		'{1'b0, bmm_pkg::OP_WRITE_B, 10'd0,    16'h8000, 1'b0, '0},
		'{1'b0, bmm_pkg::OP_COMPUTE, 10'd0,    16'h0000, 1'b1, 40'sd1073741824},
		'{1'b0, bmm_pkg::OP_WRITE_A, 10'd0,    16'h7FFF, 1'b0, '0},
		'{1'b0, bmm_pkg::OP_COMPUTE, 10'd0,    16'h0000, 1'b1, -40'sd1073709056},
		'{1'b0, bmm_pkg::OP_WRITE_B, 10'd0,    16'h7FFF, 1'b0, '0},
		'{1'b0, bmm_pkg::OP_COMPUTE, 10'd0,    16'h0000, 1'b1, 40'sd1073676289},
		'{1'b0, bmm_pkg::OP_WRITE_A, 10'd0,    16'hFFFF, 1'b0, '0},
		'{1'b0, bmm_pkg::OP_COMPUTE, 10'd0,    16'h0000, 1'b1, -40'sd32767},
		'{1'b0, bmm_pkg::OP_WRITE_A, 10'd0,    16'h0100, 1'b0, '0},
		'{1'b0, bmm_pkg::OP_WRITE_B, 10'd0,    16'h0100, 1'b0, '0},
		'{1'b0, bmm_pkg::OP_COMPUTE, 10'd0,    16'h0000, 1'b1, 40'sd65536},
		// cells beyond the result give nothing
		'{1'b0, bmm_pkg::OP_COMPUTE, 10'd1,    16'h0000, 1'b0, '0},
		'{1'b0, bmm_pkg::OP_COMPUTE, 10'd1023, 16'h0000, 1'b0, '0},
		// oversized shape registers saturate
		'{1'b1, bmm_pkg::CFG_INNER,  10'd0,    16'd31,   1'b0, '0},
		'{1'b1, bmm_pkg::CFG_ROWS,   10'd0,    16'd31,   1'b0, '0},
		'{1'b1, bmm_pkg::CFG_COLS,   10'd0,    16'd31,   1'b0, '0},
		'{1'b1, bmm_pkg::CFG_LAYERS, 10'd0,    16'd31,   1'b0, '0}
	};

	int phase_shape [PHASES][4] = '{
		'{16, 16, 16, 4},
		'{3, 5, 7, 2},
		'{1, 16, 16, 4},
		'{16, 1, 1, 1},
		'{PICK, PICK, PICK, PICK},
		'{5, 4, 3, 3},
		'{PICK, PICK, PICK, PICK},
		'{31, 2, 31, 7}
	};
	int phase_gap [PHASES] = '{30, 15, 0, 25, 10, 40, 20, 0};

	function automatic int unsigned fit(input int unsigned v, input int unsigned hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int unsigned cell_count();
		return fit(rows_reg, MAX_DIM) * fit(cols_reg, MAX_DIM) * fit(layers_reg, MAX_LAYERS);
	endfunction

	// Split a result cell into the A and B addresses of inner term k
	function automatic void operand_addr(input int unsigned idx, input int unsigned k,
			output int unsigned ai, output int unsigned bi);
		int unsigned inner, rows, cols, plane, layer, row, col;
		inner = fit(inner_reg, MAX_DIM);
		rows  = fit(rows_reg, MAX_DIM);
		cols  = fit(cols_reg, MAX_DIM);
		plane = rows * cols;
		layer = idx / plane;
		row   = (idx % plane) / cols;
		col   = idx % cols;
		ai    = k + row * inner + layer * inner * rows;
		bi    = col + k * cols + layer * inner * cols;
	endfunction

	// Exact Q24.16 dot product for one cell; zero return means no result
	function automatic bit dot_product(input int unsigned idx,
			output logic signed [bmm_pkg::SUM_W-1:0] value);
		int unsigned ai, bi, k;
		longint acc;
		value = '0;
		acc   = 0;
		if (idx >= cell_count()) return 1'b0;
		for (k = 0; k < fit(inner_reg, MAX_DIM); k++) begin
			operand_addr(idx, k, ai, bi);
			acc += longint'(a_mem[ai]) * longint'(b_mem[bi]);
		end
		value = acc[bmm_pkg::SUM_W-1:0];
		return 1'b1;
	endfunction

	function automatic logic [bmm_pkg::VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			3: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Drive one command transaction, update the shadow state at acceptance
	task automatic issue(input logic [1:0] op, input logic [bmm_pkg::IDX_W-1:0] idx,
			input logic [bmm_pkg::VAL_W-1:0] val, input bit typed,
			input logic signed [bmm_pkg::SUM_W-1:0] want);
		logic signed [bmm_pkg::SUM_W-1:0] value;
		bit produces;
		cell_t queued;
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		start         <= 1'b1;
		operation     <= op;
		flat_index    <= idx;
		element_value <= val;
		do @(posedge clk); while (busy);
		produces = 1'b0;
		case (op)
			bmm_pkg::OP_WRITE_A: begin
				a_mem[idx] = val;
				a_set[idx] = 1'b1;
			end
			bmm_pkg::OP_WRITE_B: begin
				b_mem[idx] = val;
				b_set[idx] = 1'b1;
			end
			bmm_pkg::OP_COMPUTE: produces = dot_product(idx, value);
			default: ;
		endcase
		// Queue the expected cell behind the older ones
		if (typed || produces) begin
			queued.value = typed ? want : value;
			queued.index = idx;
			pending_cells.insert(pending_cells.size(), queued);
		end
		@(negedge clk);
	endtask

	// Hold off until every cell has come back and the pipeline has drained
	task automatic settle();
		start <= 1'b0;
		while (pending_cells.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input bmm_pkg::cfg_reg_t which,
			input logic [bmm_pkg::DIM_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (which)
			bmm_pkg::CFG_INNER:  inner_reg  = data;
			bmm_pkg::CFG_ROWS:   rows_reg   = data;
			bmm_pkg::CFG_COLS:   cols_reg   = data;
			bmm_pkg::CFG_LAYERS: layers_reg = data[bmm_pkg::LAY_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// One random item; in-range computes first fill operands never written
	task automatic random_item();
		int unsigned cells, idx, ai, bi, k, area;
		int r;
		cells = cell_count();
		r = $urandom_range(0, 99);
		if (r < 50) begin
			idx = $urandom_range(0, cells - 1);
			for (k = 0; k < fit(inner_reg, MAX_DIM); k++) begin
				operand_addr(idx, k, ai, bi);
				if (!a_set[ai]) begin
					issue(bmm_pkg::OP_WRITE_A, 10'(ai), pick_value(), 1'b0, '0);
					phase_items++;
				end
				if (!b_set[bi]) begin
					issue(bmm_pkg::OP_WRITE_B, 10'(bi), pick_value(), 1'b0, '0);
					phase_items++;
				end
			end
			issue(bmm_pkg::OP_COMPUTE, 10'(idx), 16'($urandom), 1'b0, '0);
			phase_items++;
		end else if (r < 65) begin
			area = fit(inner_reg, MAX_DIM) * fit(rows_reg, MAX_DIM) * fit(layers_reg, MAX_LAYERS);
			issue(bmm_pkg::OP_WRITE_A, 10'($urandom_range(0, area - 1)), pick_value(), 1'b0, '0);
			phase_items++;
		end else if (r < 80) begin
			area = fit(inner_reg, MAX_DIM) * fit(cols_reg, MAX_DIM) * fit(layers_reg, MAX_LAYERS);
			issue(bmm_pkg::OP_WRITE_B, 10'($urandom_range(0, area - 1)), pick_value(), 1'b0, '0);
			phase_items++;
		end else if (r < 92) begin
			issue($urandom_range(0, 1) ? bmm_pkg::OP_WRITE_B : bmm_pkg::OP_WRITE_A,
				10'($urandom), pick_value(), 1'b0, '0);
			phase_items++;
		end else if (r < 96 || cells >= STORE_DEPTH) begin
			issue(OP_UNUSED, 10'($urandom), 16'($urandom), 1'b0, '0);
			phase_items++;
		end else begin
			issue(bmm_pkg::OP_COMPUTE, 10'($urandom_range(cells, STORE_DEPTH - 1)),
				16'($urandom), 1'b0, '0);
			phase_items++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Check each returned cell against the oldest expectation
	always @(posedge clk) begin
		cell_t head;
		if (arst_n && done) begin
			if (pending_cells.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual cell %0d value %0d",
					$time, cell_index, cell_value);
				failures++;
			end else begin
				head = pending_cells.pop_front();
				cells_checked++;
				if (cell_value !== head.value) begin
					$display("%0t: cell_value mismatch: expected %0d, actual %0d",
						$time, head.value, cell_value);
					failures++;
				end
				if (cell_index !== head.index) begin
					$display("%0t: cell_index mismatch: expected %0d, actual %0d",
						$time, head.index, cell_index);
					failures++;
				end
			end
		end
	end

	// Abort when no transaction of any kind moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_batched_matrix_multiply failed");
			$finish;
		end
	end

	initial begin
		int p, r, i;
		arst_n        = 1'b0;
		start         = 1'b0;
		operation     = bmm_pkg::OP_WRITE_A;
		flat_index    = '0;
		element_value = '0;
		cfg_valid     = 1'b0;
		cfg_index     = bmm_pkg::CFG_INNER;
		cfg_data      = '0;
		failures      = 0;
		cells_checked = 0;
		items_sent    = 0;
		stall_cycles  = 0;
		gap_pct       = 20;
		inner_reg     = 5'd16;
		rows_reg      = 5'd16;
		cols_reg      = 5'd16;
		layers_reg    = 3'd4;
		for (i = 0; i < STORE_DEPTH; i++) begin
			a_mem[i] = '0;
			b_mem[i] = '0;
			a_set[i] = 1'b0;
			b_set[i] = 1'b0;
		end
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed steps
		for (r = 0; r < PLAN_ROWS; r++) begin
			if (plan[r].is_cfg) begin
				settle();
				write_reg(bmm_pkg::cfg_reg_t'(plan[r].code), plan[r].data[bmm_pkg::DIM_W-1:0]);
			end else begin
				issue(plan[r].code, plan[r].idx, plan[r].data, plan[r].typed, plan[r].want);
				items_sent++;
			end
		end

		// Random phases, each under its own shape
		for (p = 0; p < PHASES; p++) begin
			settle();
			for (r = 0; r < 4; r++)
				write_reg(bmm_pkg::cfg_reg_t'(r), (phase_shape[p][r] == PICK) ?
					5'($urandom_range(0, (r == 3) ? 7 : 31)) : 5'(phase_shape[p][r]));
			gap_pct = phase_gap[p];
			phase_items = 0;
			while (phase_items < PHASE_ITEMS)
				random_item();
			items_sent += phase_items;
		end
		settle();

		$display("Ran %0d command transactions over %0d shape settings; %0d cells checked.",
			items_sent, PHASES + 2, cells_checked);
		$display("Shapes spanned zero, in-range and saturating register values.");
		if (failures == 0)
			$display("tb_batched_matrix_multiply passed");
		else
			$display("tb_batched_matrix_multiply failed");
		$finish;
	end

endmodule
